// ===== src/diagnostic_event_status_table_top_macros.svh =====
// assertion macros for the diagnostic event status table
`ifndef DIAGNOSTIC_EVENT_STATUS_TABLE_TOP_MACROS_SVH
`define DIAGNOSTIC_EVENT_STATUS_TABLE_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define DEST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DEST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dest_pkg.sv =====
// shared types and constants of the diagnostic event status table
package dest_pkg;

  // command codes
  localparam logic [1:0] CMD_REPORT = 2'd0;
  localparam logic [1:0] CMD_GET    = 2'd1;
  localparam logic [1:0] CMD_RESET  = 2'd2;

  // event status codes
  localparam logic [7:0] ST_PASSED    = 8'd0;
  localparam logic [7:0] ST_FAILED    = 8'd1;
  localparam logic [7:0] ST_PREPASSED = 8'd2;
  localparam logic [7:0] ST_PREFAILED = 8'd3;

  // failure counter ceiling
  localparam logic [7:0] COUNT_MAX = 8'd255;

  // result codes
  localparam logic RC_OK     = 1'b0;
  localparam logic RC_NOT_OK = 1'b1;

  // one table entry as held in memory
  typedef struct packed {
    logic [15:0] event_id;
    logic [7:0]  status;
    logic [7:0]  fail_count;
  } entry_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

// ===== src/dest_if.sv =====
// request and result channel interfaces of the diagnostic event status table
interface dest_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] event_id;
  logic [7:0]  event_status;

  modport source(output valid, command, event_id, event_status, input ready);
  modport sink(input valid, command, event_id, event_status, output ready);
endinterface

interface dest_out_if;
  logic       valid;
  logic       ready;
  logic       result_code;
  logic [7:0] read_status;
  logic [7:0] fail_count;

  modport source(output valid, result_code, read_status, fail_count, input ready);
  modport sink(input valid, result_code, read_status, fail_count, output ready);
endinterface

// ===== src/dest_table_ram.sv =====
// entry memory: one write port, one read port with registered read data
module dest_table_ram
  import dest_pkg::*;
#(
  parameter int ENTRIES = 64,
  parameter int AW      = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem_r [ENTRIES];
  entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/dest_ctrl.sv =====
// request sequencer: scans the filled part of the table, updates one entry, drives the result
module dest_ctrl
  import dest_pkg::*;
#(
  parameter int ENTRIES = 64,
  parameter int AW      = 6,
  parameter int CW      = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  dest_in_if.sink       in_bus,
  dest_out_if.source    out_bus,
  output logic [AW-1:0] rd_addr,
  input  entry_t        rd_data,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output entry_t        wr_data,
  output logic [CW-1:0] fill_cnt
);

  state_t        state_r, state_nxt;
  logic [CW-1:0] scan_r;
  logic [CW-1:0] fill_r;
  logic [1:0]    cmd_r;
  logic [15:0]   id_r;
  logic [7:0]    st_r;
  logic          found_r;
  logic [AW-1:0] slot_r;
  entry_t        entry_r;

  logic          out_valid_r;
  logic          out_code_r;
  logic [7:0]    out_rd_r;
  logic [7:0]    out_cnt_r;

  logic          in_xfer;
  logic          out_free;
  logic          hit;
  logic          last;
  logic [CW-1:0] scan_inc;
  logic          room;

  entry_t        upd;
  logic          do_wr;
  logic          do_alloc;
  logic          res_code;
  logic [7:0]    res_rd;
  logic [7:0]    res_cnt;

  assign in_xfer  = in_bus.valid && in_bus.ready;
  assign out_free = !out_valid_r || out_bus.ready;
  assign scan_inc = scan_r + CW'(1);
  assign hit      = (rd_data.event_id == id_r);
  assign last     = (scan_inc == fill_r);
  assign room     = (fill_r < CW'(ENTRIES));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = (fill_r == '0) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit || last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_bus.ready = (state_r == S_IDLE);
    rd_addr      = (state_r == S_SCAN) ? scan_inc[AW-1:0] : '0;
    wr_en        = (state_r == S_DONE) && out_free && do_wr;
    wr_addr      = found_r ? slot_r : fill_r[AW-1:0];
    wr_data      = upd;
  end

  // entry update and result for the current command
  always_comb begin
    upd      = entry_r;
    do_wr    = 1'b0;
    do_alloc = 1'b0;
    res_code = RC_NOT_OK;
    res_rd   = '0;
    res_cnt  = '0;
    unique case (cmd_r)
      CMD_REPORT: begin
        if (!found_r) begin
          upd.event_id   = id_r;
          upd.status     = ST_PASSED;
          upd.fail_count = '0;
        end
        if (found_r || room) begin
          do_alloc   = !found_r;
          do_wr      = 1'b1;
          upd.status = st_r;
          res_code   = RC_OK;
          priority if (st_r == ST_FAILED) begin
            if (upd.fail_count != COUNT_MAX) begin
              upd.fail_count = upd.fail_count + 8'd1;
            end
          end else if (st_r == ST_PASSED) begin
            upd.fail_count = '0;
          end else if (st_r == ST_PREPASSED || st_r == ST_PREFAILED) begin
            upd.fail_count = upd.fail_count;
          end else begin
            res_code = RC_NOT_OK;
          end
          res_cnt = upd.fail_count;
        end
      end
      CMD_GET: begin
        if (found_r) begin
          res_code = RC_OK;
          res_rd   = entry_r.status;
          res_cnt  = entry_r.fail_count;
        end
      end
      CMD_RESET: begin
        if (found_r) begin
          upd.status     = ST_PASSED;
          upd.fail_count = '0;
          do_wr          = 1'b1;
          res_code       = RC_OK;
        end
      end
      default: begin
        res_code = RC_NOT_OK;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
        if (do_alloc) begin
          fill_r <= fill_r + CW'(1);
        end
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request capture and scan
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r   <= in_bus.command;
      id_r    <= in_bus.event_id;
      st_r    <= in_bus.event_status;
      scan_r  <= '0;
      found_r <= 1'b0;
    end else if (state_r == S_SCAN) begin
      if (hit) begin
        found_r <= 1'b1;
        entry_r <= rd_data;
        slot_r  <= scan_r[AW-1:0];
      end else if (!last) begin
        scan_r <= scan_inc;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_code_r <= res_code;
      out_rd_r   <= res_rd;
      out_cnt_r  <= res_cnt;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.result_code = out_code_r;
  assign out_bus.read_status = out_rd_r;
  assign out_bus.fail_count  = out_cnt_r;
  assign fill_cnt            = fill_r;

endmodule

// ===== src/diagnostic_event_status_table_top.sv =====
// top level of the diagnostic event status table
//
// Usage:
//   in_bus carries one request per transfer: command (report, get, reset),
//   event_id and event_status. out_bus returns exactly one result per
//   request: result_code, read_status and fail_count, in request order.
//   Entries sit in a single-port-read memory and fill from slot 0 upward;
//   they are released only by reset, so a fill count marks the used slots.
//   After its transfer a request scans the table, one memory read per
//   scanned slot, up to the matching slot or, when the id is absent, up
//   to the fill count, then passes the done state to the result register.
//   The next request is taken only when the sequencer is back in idle,
//   after the result of the last one has been registered.
//   Reset (synchronous, active low) empties the table by clearing the
//   fill count; no clearing pass is needed.
//   A stalled receiver holds the result in the output register; the next
//   request is still taken and scanned, and waits only for the result slot.
module diagnostic_event_status_table_top
  import dest_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input logic        clk,
  input logic        rst_n,
  dest_in_if.sink    in_bus,
  dest_out_if.source out_bus
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  logic [AW-1:0] rd_addr;
  entry_t        rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic [CW-1:0] fill_cnt;

  // sequencer
  dest_ctrl #(
    .ENTRIES(TABLE_ENTRIES),
    .AW     (AW),
    .CW     (CW)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .fill_cnt(fill_cnt)
  );

  // entry memory
  dest_table_ram #(
    .ENTRIES(TABLE_ENTRIES),
    .AW     (AW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // checks
`include "diagnostic_event_status_table_top_macros.svh"

  `DEST_ASSERT_NOW(a_fill_bound, 1'b1, fill_cnt <= CW'(TABLE_ENTRIES), "fill count above table size")
  `DEST_ASSERT_NOW(a_fill_step, !$stable(fill_cnt), fill_cnt == $past(fill_cnt) + CW'(1), "fill count moved by other than one")
  `DEST_ASSERT_NEXT(a_one_request, in_bus.valid && in_bus.ready, !in_bus.ready, "request taken while busy")
  `DEST_ASSERT_NOW(a_write_in_range, wr_en, {1'b0, wr_addr} < (AW+1)'(TABLE_ENTRIES), "write beyond table")

endmodule

// ===== tb/sv/diagnostic_event_status_table_checker.sv =====
// scoreboard that predicts and checks every result of the diagnostic event status table
module diagnostic_event_status_table_checker
  import dest_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  dest_in_if          in_mon,
  dest_out_if         out_mon,
  output int unsigned error_count,
  output int unsigned outstanding
);

  localparam int unsigned PRINT_CAP = 50;

  typedef struct packed {
    logic       result_code;
    logic [7:0] read_status;
    logic [7:0] fail_count;
  } event_result_t;

  // shadow copy of the event table
  logic        tbl_used   [TABLE_ENTRIES];
  logic [15:0] tbl_id     [TABLE_ENTRIES];
  logic [7:0]  tbl_status [TABLE_ENTRIES];
  logic [7:0]  tbl_count  [TABLE_ENTRIES];

  event_result_t expected_results[$];
  int unsigned   result_index;

  // lowest used slot holding this id, or -1
  function automatic int lookup_slot(logic [15:0] id);
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (tbl_used[k] && tbl_id[k] == id) return k;
    end
    return -1;
  endfunction

  // lowest unused slot, or -1 when the table is full
  function automatic int first_free_slot();
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (!tbl_used[k]) return k;
    end
    return -1;
  endfunction

  // apply one request to the shadow table and return its result
  function automatic event_result_t apply_request(logic [1:0] cmd, logic [15:0] id,
                                                  logic [7:0] st);
    event_result_t res;
    int slot;
    res.result_code = RC_NOT_OK;
    res.read_status = 8'd0;
    res.fail_count  = 8'd0;
    slot = lookup_slot(id);
    case (cmd)
      CMD_REPORT: begin
        // allocate on first report of an id
        if (slot < 0) begin
          slot = first_free_slot();
          if (slot >= 0) begin
            tbl_used[slot]   = 1'b1;
            tbl_id[slot]     = id;
            tbl_status[slot] = ST_PASSED;
            tbl_count[slot]  = 8'd0;
          end
        end
        if (slot >= 0) begin
          tbl_status[slot] = st;
          res.result_code  = RC_OK;
          if (st == ST_FAILED) begin
            if (tbl_count[slot] != COUNT_MAX) tbl_count[slot] = tbl_count[slot] + 8'd1;
          end else if (st == ST_PASSED) begin
            tbl_count[slot] = 8'd0;
          end else if (st != ST_PREPASSED && st != ST_PREFAILED) begin
            res.result_code = RC_NOT_OK;
          end
          res.fail_count = tbl_count[slot];
        end
      end
      CMD_GET: begin
        if (slot >= 0) begin
          res.result_code = RC_OK;
          res.read_status = tbl_status[slot];
          res.fail_count  = tbl_count[slot];
        end
      end
      CMD_RESET: begin
        if (slot >= 0) begin
          tbl_status[slot] = ST_PASSED;
          tbl_count[slot]  = 8'd0;
          res.result_code  = RC_OK;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string text);
    if (error_count < PRINT_CAP) $display("ERROR at %0t: %s", $realtime, text);
    error_count = error_count + 1;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d: %s got %0h want %0h", result_index, name, got,
                                want));
    end
  endtask

  // result side first: a result can never belong to a request taken on the same edge
  always @(posedge clk) begin
    event_result_t want;
    if (!rst_n) begin
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        tbl_used[k]   = 1'b0;
        tbl_id[k]     = 16'd0;
        tbl_status[k] = 8'd0;
        tbl_count[k]  = 8'd0;
      end
      expected_results.delete();
      result_index = 0;
      error_count  = 0;
      outstanding <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                    result_index));
        end else begin
          want = expected_results.pop_front();
          check_field("result_code", {7'd0, out_mon.result_code}, {7'd0, want.result_code});
          check_field("read_status", out_mon.read_status, want.read_status);
          check_field("fail_count", out_mon.fail_count, want.fail_count);
        end
        result_index = result_index + 1;
      end
      // request transfer
      if (in_mon.valid && in_mon.ready) begin
        expected_results.push_back(apply_request(in_mon.command, in_mon.event_id,
                                                 in_mon.event_status));
      end
      outstanding <= expected_results.size();
    end
  end

endmodule

// ===== tb/sv/diagnostic_event_status_table_top_tb.sv =====
// stimulus, clocking and verdict for the diagnostic event status table
module diagnostic_event_status_table_top_tb;
  import dest_pkg::*;

  localparam int          TABLE_ENTRIES   = 64;
  localparam logic [1:0]  CMD_UNUSED      = 2'd3;
  localparam int          RANDOM_ITEMS    = 1600;
  localparam int          SATURATION_RUN  = 270;
  localparam int          SATURATION_AT   = 600;
  localparam int unsigned HOLD_OFF_AT     = 500;
  localparam int          HOLD_OFF_CYCLES = 800;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned error_count;
  int unsigned outstanding;
  int unsigned cycle_count = 0;
  int unsigned sent_count = 0;
  int unsigned taken_count = 0;
  logic [15:0] known_ids[$];

  dest_in_if  in_bus();
  dest_out_if out_bus();

  diagnostic_event_status_table_top #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  diagnostic_event_status_table_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .error_count(error_count),
    .outstanding(outstanding)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // idle cycles before the next transfer; some stretches run without gaps
  function automatic int draw_gap(int unsigned count);
    if ((count / 150) % 4 == 3) return 0;
    return $urandom_range(0, 15);
  endfunction

  function automatic bit is_known(logic [15:0] id);
    foreach (known_ids[k]) begin
      if (known_ids[k] == id) return 1'b1;
    end
    return 1'b0;
  endfunction

  // offer one request and hold it until the transfer
  task automatic send_request(logic [1:0] cmd, logic [15:0] id, logic [7:0] st);
    int gap;
    gap = draw_gap(sent_count);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.command      <= cmd;
    in_bus.event_id     <= id;
    in_bus.event_status <= st;
    do @(posedge clk); while (!in_bus.ready);
    sent_count++;
  endtask

  // result side, with one long hold-off that backs up the block
  initial begin
    int hold;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold = (taken_count == HOLD_OFF_AT) ? HOLD_OFF_CYCLES : draw_gap(taken_count);
      if (hold > 0) begin
        out_bus.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      taken_count++;
    end
  end

  // request side
  initial begin
    logic [1:0]  cmd;
    logic [15:0] id;
    logic [7:0]  st;
    int          pick;
    rst_n               <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.command      <= CMD_REPORT;
    in_bus.event_id     <= 16'd0;
    in_bus.event_status <= ST_PASSED;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: absent ids, unused command, every status, id extremes
    send_request(CMD_GET, 16'h1234, ST_PASSED);
    send_request(CMD_RESET, 16'h1234, ST_PASSED);
    send_request(CMD_UNUSED, 16'hFFFF, 8'hFF);
    send_request(CMD_REPORT, 16'h0000, ST_PREPASSED);
    send_request(CMD_REPORT, 16'h0000, ST_FAILED);
    send_request(CMD_REPORT, 16'h0000, ST_FAILED);
    send_request(CMD_REPORT, 16'h0000, ST_PREFAILED);
    send_request(CMD_GET, 16'h0000, ST_PASSED);
    send_request(CMD_UNUSED, 16'h0000, ST_FAILED);
    send_request(CMD_REPORT, 16'h0000, ST_PASSED);
    send_request(CMD_GET, 16'h0000, 8'hFF);
    send_request(CMD_REPORT, 16'hFFFF, ST_FAILED);
    send_request(CMD_REPORT, 16'hFFFF, 8'hFF);
    send_request(CMD_REPORT, 16'hFFFF, 8'd4);
    send_request(CMD_GET, 16'hFFFF, ST_PASSED);
    send_request(CMD_RESET, 16'hFFFF, ST_FAILED);
    send_request(CMD_GET, 16'hFFFF, ST_PASSED);
    // unknown status on a fresh id still allocates
    send_request(CMD_REPORT, 16'h8000, 8'h80);
    send_request(CMD_GET, 16'h8000, ST_PASSED);
    send_request(CMD_REPORT, 16'h5555, 8'hAA);
    send_request(CMD_REPORT, 16'hAAAA, 8'h55);
    send_request(CMD_RESET, 16'h5555, ST_PASSED);
    known_ids = '{16'h0000, 16'hFFFF, 16'h8000, 16'h5555, 16'hAAAA};

    // random mix over a pool of live ids; the table fills and stays full
    for (int n = 0; n < RANDOM_ITEMS - SATURATION_RUN; n++) begin
      // long run of failures drives one counter into saturation
      if (n == SATURATION_AT) begin
        for (int s = 0; s < SATURATION_RUN; s++) begin
          if (s % 20 == 19) send_request(CMD_GET, known_ids[0], ST_PASSED);
          else send_request(CMD_REPORT, known_ids[0], ST_FAILED);
        end
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) cmd = CMD_REPORT;
      else if (pick < 75) cmd = CMD_GET;
      else if (pick < 95) cmd = CMD_RESET;
      else cmd = CMD_UNUSED;
      if ($urandom_range(0, 99) < 20) id = 16'($urandom);
      else id = known_ids[$urandom_range(0, known_ids.size() - 1)];
      pick = $urandom_range(0, 99);
      if (pick < 35) st = ST_FAILED;
      else if (pick < 55) st = ST_PASSED;
      else if (pick < 70) st = ST_PREPASSED;
      else if (pick < 85) st = ST_PREFAILED;
      else st = 8'($urandom);
      if (cmd == CMD_REPORT && known_ids.size() < TABLE_ENTRIES && !is_known(id)) begin
        known_ids.push_back(id);
      end
      send_request(cmd, id, st);
    end
    in_bus.valid <= 1'b0;

    // drain, then allow one full scan for anything stray
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TABLE_ENTRIES + 8) @(posedge clk);
    if (error_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
